// File: hdl/dhb_pkg.sv
// ----------------------------------------------------------------------------
// Dual bridge controller package
// Shared opcodes, state encoding and small helpers.
// ----------------------------------------------------------------------------
package dhb_pkg;

    typedef enum logic [2:0] {
        OP_RUN      = 3'd0,
        OP_RAMP     = 3'd1,
        OP_BRAKE    = 3'd2,
        OP_COAST    = 3'd3,
        OP_STBY_ON  = 3'd4,
        OP_STBY_OFF = 3'd5,
        OP_ESTOP    = 3'd6,
        OP_TICK     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_RUN,
        ST_DIV_DONE,
        ST_OUT_PULSE,
        ST_OUT_FINAL
    } state_t;

    // Bridge pin encodings: bit 1 is in1, bit 0 is in2.
    localparam logic [1:0] PINS_OFF   = 2'b00;
    localparam logic [1:0] PINS_CCW   = 2'b01;
    localparam logic [1:0] PINS_CW    = 2'b10;
    localparam logic [1:0] PINS_BRAKE = 2'b11;

    localparam int DIV_BITS = 32;

    // Request to the serial divider.
    typedef struct packed {
        logic        start;
        logic [9:0]  delta;
        logic [31:0] num_mul;
        logic [31:0] den;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [9:0]  quot;
    } div_rsp_t;

    function automatic logic [1:0] dir_pins(input logic d);
        return d ? PINS_CCW : PINS_CW;
    endfunction

endpackage

// File: hdl/dhb_divider.sv
// ----------------------------------------------------------------------------
// Serial ramp divider
// Computes delta * elapsed / length one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dhb_divider
(
    input  logic              clk,
    input  logic              rst_n,
    input  dhb_pkg::div_req_t req,
    output dhb_pkg::div_rsp_t rsp
);

    // Product is at most 42 bits; quotient fits 10 bits since elapsed < length.
    localparam int PW = 42;

    logic [PW-1:0] rem_reg, rem_next;
    logic [PW-1:0] dvd_reg, dvd_next;
    logic [31:0]   den_reg, den_next;
    logic [9:0]    quot_reg, quot_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [PW-1:0] rem_sh;
    logic [PW:0]   trial;

    // One restoring step per cycle on the multiplied numerator.
    always_comb
    begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg[PW-2:0], dvd_reg[PW-1]};
        trial     = {1'b0, rem_sh} - {11'd0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            dvd_next  = PW'(req.delta) * PW'(req.num_mul);
            den_next  = req.den;
            quot_next = '0;
            cnt_next  = 6'(PW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[PW-2:0], 1'b0};
            if (!trial[PW])
            begin
                rem_next  = trial[PW-1:0];
                quot_next = {quot_reg[8:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_sh;
                quot_next = {quot_reg[8:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |=> busy_reg) else $error("divider did not start");
    a_cnt_zero_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cnt_reg == 6'd0 || $past(req.start) == 1'b0))
        else $error("divider count left over");

endmodule

// File: hdl/dual_hbridge_speed_ramp_controller.sv
// ----------------------------------------------------------------------------
// Dual H-bridge speed ramp controller
// Two bridge channels with run, brake, coast, standby and linear ramps.
// ----------------------------------------------------------------------------
// Commands other than a tick that has a ramping channel give their first result
// beat in the cycle after accept. Such a tick runs a serial divide per ramping
// channel, one channel after the other on the single divider, before its result.
// Throughput: one item at a time; the next item is taken once all results go.
// Reset: both channels stopped, pins low, clockwise, standby pin high,
// ramp_enable high.
module dual_hbridge_speed_ramp_controller #(
    parameter int SPEED_MAX = 1000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  op,
    input  logic        channel,
    input  logic        direction,
    input  logic [9:0]  speed,
    input  logic [31:0] ramp_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  pwm_a,
    output logic [9:0]  pwm_b,
    output logic        in1_a,
    output logic        in2_a,
    output logic        in1_b,
    output logic        in2_b,
    output logic        standby_pin,
    output logic        dir_a,
    output logic        dir_b,
    output logic        last
);

    localparam logic [9:0] SMAX = 10'(SPEED_MAX);

    dhb_pkg::state_t state_reg, state_next;

    logic        ramp_en_reg;
    logic [9:0]  spd_reg   [2];
    logic        dir_reg   [2];
    logic [1:0]  pins_reg  [2];
    logic        busy_reg  [2];
    logic [9:0]  from_reg  [2];
    logic [9:0]  to_reg    [2];
    logic [31:0] elap_reg  [2];
    logic [31:0] len_reg   [2];
    logic        stby_reg;
    logic        ch_reg;     // channel under tick division
    logic        pend_reg;   // second channel still to tick

    // Snapshot registers holding the brake pulse beat.
    logic [9:0]  o_pwm_reg [2];
    logic [1:0]  o_pins_reg [2];
    logic        o_dir_reg [2];
    logic        o_stby_reg;

    dhb_pkg::div_req_t dreq;
    dhb_pkg::div_rsp_t drsp;

    logic        accept;
    logic [9:0]  spd_sat;
    logic        c;
    logic        dirchg;
    logic [31:0] e_inc;
    logic [9:0]  fr, tt, delta;
    logic [10:0] sum;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == dhb_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == dhb_pkg::ST_IDLE) && !in_valid;
    assign out_valid = (state_reg == dhb_pkg::ST_OUT_PULSE) ||
                       (state_reg == dhb_pkg::ST_OUT_FINAL);
    assign spd_sat   = (speed > SMAX) ? SMAX : speed;
    assign c         = channel;
    assign dirchg    = (direction != dir_reg[c]);

    // Divider request for the current tick channel.
    assign e_inc = (elap_reg[ch_reg] == 32'hFFFF_FFFF) ? elap_reg[ch_reg]
                                                      : elap_reg[ch_reg] + 32'd1;
    assign fr    = from_reg[ch_reg];
    assign tt    = to_reg[ch_reg];
    assign delta = (tt >= fr) ? tt - fr : fr - tt;
    assign dreq.start   = (state_reg == dhb_pkg::ST_DIV_START);
    assign dreq.delta   = delta;
    assign dreq.num_mul = e_inc;
    assign dreq.den     = len_reg[ch_reg];
    assign sum = {1'b0, fr} + {1'b0, drsp.quot};

    dhb_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dhb_pkg::ST_IDLE:
                if (accept)
                begin
                    if (op == dhb_pkg::OP_TICK && ramp_en_reg && (busy_reg[0] || busy_reg[1]))
                        state_next = dhb_pkg::ST_DIV_START;
                    else if ((op == dhb_pkg::OP_RUN ||
                              (op == dhb_pkg::OP_RAMP)) && dirchg)
                        state_next = dhb_pkg::ST_OUT_PULSE;
                    else
                        state_next = dhb_pkg::ST_OUT_FINAL;
                end
            dhb_pkg::ST_DIV_START:
                state_next = dhb_pkg::ST_DIV_RUN;
            dhb_pkg::ST_DIV_RUN:
                if (drsp.done)
                    state_next = dhb_pkg::ST_DIV_DONE;
            dhb_pkg::ST_DIV_DONE:
                state_next = pend_reg ? dhb_pkg::ST_DIV_START : dhb_pkg::ST_OUT_FINAL;
            dhb_pkg::ST_OUT_PULSE:
                if (out_ready)
                    state_next = dhb_pkg::ST_OUT_FINAL;
            dhb_pkg::ST_OUT_FINAL:
                if (out_ready)
                    state_next = dhb_pkg::ST_IDLE;
            default:
                state_next = dhb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= dhb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ramp_en_reg <= 1'b1;
        else if (cfg_valid && cfg_ready)
            ramp_en_reg <= cfg_data;
    end

    // Channel state updates; the brake pulse snapshot is taken at accept.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 2; i++)
            begin
                spd_reg[i]  <= '0;
                dir_reg[i]  <= 1'b0;
                pins_reg[i] <= dhb_pkg::PINS_OFF;
                busy_reg[i] <= 1'b0;
            end
            stby_reg <= 1'b1;
            ch_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            unique case (dhb_pkg::op_t'(op))
                dhb_pkg::OP_RUN:
                begin
                    busy_reg[c] <= 1'b0;
                    dir_reg[c]  <= direction;
                    pins_reg[c] <= dhb_pkg::dir_pins(direction);
                    spd_reg[c]  <= spd_sat;
                end
                dhb_pkg::OP_RAMP:
                begin
                    dir_reg[c]  <= direction;
                    pins_reg[c] <= dhb_pkg::dir_pins(direction);
                    if (!ramp_en_reg || ramp_ms == 32'd0)
                    begin
                        busy_reg[c] <= 1'b0;
                        spd_reg[c]  <= spd_sat;
                    end
                    else
                    begin
                        busy_reg[c] <= 1'b1;
                        if (dirchg)
                            spd_reg[c] <= SMAX;
                    end
                end
                dhb_pkg::OP_BRAKE:
                begin
                    busy_reg[c] <= 1'b0;
                    pins_reg[c] <= dhb_pkg::PINS_BRAKE;
                    spd_reg[c]  <= SMAX;
                end
                dhb_pkg::OP_COAST:
                begin
                    busy_reg[c] <= 1'b0;
                    pins_reg[c] <= dhb_pkg::PINS_OFF;
                    spd_reg[c]  <= '0;
                end
                dhb_pkg::OP_STBY_ON:
                begin
                    for (int i = 0; i < 2; i++)
                    begin
                        busy_reg[i] <= 1'b0;
                        pins_reg[i] <= dhb_pkg::PINS_OFF;
                        spd_reg[i]  <= '0;
                    end
                    stby_reg <= 1'b0;
                end
                dhb_pkg::OP_STBY_OFF:
                    stby_reg <= 1'b1;
                dhb_pkg::OP_ESTOP:
                    for (int i = 0; i < 2; i++)
                    begin
                        busy_reg[i] <= 1'b0;
                        pins_reg[i] <= dhb_pkg::PINS_BRAKE;
                        spd_reg[i]  <= SMAX;
                    end
                default:
                begin
                    // Tick: queue the ramping channels, A first.
                    ch_reg   <= busy_reg[0] ? 1'b0 : 1'b1;
                    pend_reg <= busy_reg[0] && busy_reg[1];
                end
            endcase
        end
        else if (state_reg == dhb_pkg::ST_DIV_START)
        begin
            // Ramp end check uses the incremented elapsed count.
            if (e_inc >= len_reg[ch_reg])
            begin
                spd_reg[ch_reg]  <= tt;
                busy_reg[ch_reg] <= 1'b0;
            end
        end
        else if (state_reg == dhb_pkg::ST_DIV_DONE)
        begin
            if (busy_reg[ch_reg])
            begin
                if (tt >= fr)
                    spd_reg[ch_reg] <= (sum > {1'b0, SMAX}) ? SMAX : sum[9:0];
                else
                    spd_reg[ch_reg] <= (drsp.quot > fr) ? 10'd0 : fr - drsp.quot;
            end
            ch_reg   <= 1'b1;
            pend_reg <= 1'b0;
        end
    end

    // Ramp parameters, written at ramp start and elapsed bump at tick.
    always_ff @(posedge clk)
    begin
        if (accept && op == dhb_pkg::OP_RAMP && ramp_en_reg && ramp_ms != 32'd0)
        begin
            from_reg[c] <= dirchg ? SMAX : spd_reg[c];
            to_reg[c]   <= spd_sat;
            elap_reg[c] <= '0;
            len_reg[c]  <= ramp_ms;
        end
        else if (state_reg == dhb_pkg::ST_DIV_START)
            elap_reg[ch_reg] <= e_inc;
    end

    // Brake pulse snapshot, taken at accept and held while the beat waits.
    always_ff @(posedge clk)
    begin
        if (accept && state_next == dhb_pkg::ST_OUT_PULSE)
        begin
            for (int i = 0; i < 2; i++)
            begin
                o_pwm_reg[i]  <= (1'(i) == c) ? SMAX : spd_reg[i];
                o_pins_reg[i] <= (1'(i) == c) ? dhb_pkg::PINS_BRAKE : pins_reg[i];
                o_dir_reg[i]  <= dir_reg[i];
            end
            o_stby_reg <= stby_reg;
        end
    end

    // The final beat shows the updated state directly; the pulse comes from the snapshot.
    logic [9:0] pwm_f [2];
    logic [1:0] pins_f [2];
    logic       dir_f [2];
    logic       stby_f;
    logic       show_live;
    assign show_live = (state_reg == dhb_pkg::ST_OUT_FINAL);
    always_comb
    begin
        for (int i = 0; i < 2; i++)
        begin
            pwm_f[i]  = show_live ? spd_reg[i]  : o_pwm_reg[i];
            pins_f[i] = show_live ? pins_reg[i] : o_pins_reg[i];
            dir_f[i]  = show_live ? dir_reg[i]  : o_dir_reg[i];
        end
        stby_f = show_live ? stby_reg : o_stby_reg;
    end

    assign pwm_a       = pwm_f[0];
    assign pwm_b       = pwm_f[1];
    assign in1_a       = pins_f[0][1];
    assign in2_a       = pins_f[0][0];
    assign in1_b       = pins_f[1][1];
    assign in2_b       = pins_f[1][0];
    assign dir_a       = dir_f[0];
    assign dir_b       = dir_f[1];
    assign standby_pin = stby_f;
    assign last        = show_live;

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during output");
    a_pulse_then_final: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == dhb_pkg::ST_OUT_PULSE && out_ready) |=>
        state_reg == dhb_pkg::ST_OUT_FINAL) else $error("pulse not followed by final");
    a_speed_cap: assert property (@(posedge clk) disable iff (!rst_n)
        spd_reg[0] <= SMAX && spd_reg[1] <= SMAX) else $error("speed over max");

endmodule

// File: bench/dhb_checker.sv
// ----------------------------------------------------------------------------
// Dual bridge controller checker
// Watches the command, config and result channels, predicts every result
// beat from its own copy of the channel state and compares each beat whole.
// ----------------------------------------------------------------------------
module dhb_checker
#(
    parameter int SPEED_MAX = 1000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  op,
    input  logic        channel,
    input  logic        direction,
    input  logic [9:0]  speed,
    input  logic [31:0] ramp_ms,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [9:0]  pwm_a,
    input  logic [9:0]  pwm_b,
    input  logic        in1_a,
    input  logic        in2_a,
    input  logic        in1_b,
    input  logic        in2_b,
    input  logic        standby_pin,
    input  logic        dir_a,
    input  logic        dir_b,
    input  logic        last,
    output int          fail_count,
    output int          pending,
    output int          beats_seen,
    output int          pulses_seen
);

    // One result snapshot, packed so a whole beat compares at once.
    typedef struct packed {
        logic [9:0] pwm_a;
        logic [9:0] pwm_b;
        logic       in1_a;
        logic       in2_a;
        logic       in1_b;
        logic       in2_b;
        logic       stby;
        logic       dir_a;
        logic       dir_b;
        logic       last;
    } snap_t;

    snap_t snap_q[$];

    // Predicted controller state.
    logic        tick_en;
    logic [9:0]  duty [2];
    logic        heading [2];
    logic [1:0]  pins [2];
    logic        ramping [2];
    logic [9:0]  start_duty [2];
    logic [9:0]  goal_duty [2];
    logic [31:0] ms_done [2];
    logic [31:0] ms_total [2];
    logic        stby_lvl;

    function automatic logic [9:0] sat_duty(input logic [9:0] s);
        return (s > SPEED_MAX) ? 10'(SPEED_MAX) : s;
    endfunction

    task automatic push_snapshot(input logic fin);
        snap_t s;
        s.pwm_a = duty[0];
        s.pwm_b = duty[1];
        s.in1_a = pins[0][1];
        s.in2_a = pins[0][0];
        s.in1_b = pins[1][1];
        s.in2_b = pins[1][0];
        s.stby  = stby_lvl;
        s.dir_a = heading[0];
        s.dir_b = heading[1];
        s.last  = fin;
        snap_q.push_back(s);
    endtask

    task automatic brake_beat(input int ch);
        pins[ch] = dhb_pkg::PINS_BRAKE;
        duty[ch] = 10'(SPEED_MAX);
        push_snapshot(1'b0);
    endtask

    task automatic drive_now(input int ch, input logic d, input logic [9:0] spd);
        ramping[ch] = 1'b0;
        if (d != heading[ch])
            brake_beat(ch);
        heading[ch] = d;
        pins[ch] = dhb_pkg::dir_pins(d);
        duty[ch] = spd;
    endtask

    // Advance one channel's ramp by a millisecond, interpolating up or down on the unsigned span.
    task automatic advance_ramp(input int ch);
        logic [63:0] span;
        logic [63:0] step;
        if (!ramping[ch])
            return;
        if (ms_done[ch] != 32'hFFFF_FFFF)
            ms_done[ch] = ms_done[ch] + 32'd1;
        if (ms_total[ch] == 0 || ms_done[ch] >= ms_total[ch])
        begin
            duty[ch] = goal_duty[ch];
            ramping[ch] = 1'b0;
            return;
        end
        span = (goal_duty[ch] >= start_duty[ch]) ? 64'(goal_duty[ch] - start_duty[ch])
                                                   : 64'(start_duty[ch] - goal_duty[ch]);
        step = span * 64'(ms_done[ch]) / 64'(ms_total[ch]);
        if (goal_duty[ch] >= start_duty[ch])
            duty[ch] = sat_duty(10'(64'(start_duty[ch]) + step));
        else
            duty[ch] = (step > 64'(start_duty[ch])) ? 10'd0 : 10'(64'(start_duty[ch]) - step);
    endtask

    task automatic predict_command(input dhb_pkg::op_t o, input int ch, input logic d,
                                   input logic [9:0] raw_spd, input logic [31:0] len);
        logic [9:0] spd;
        spd = sat_duty(raw_spd);
        case (o)
            dhb_pkg::OP_RUN:
                drive_now(ch, d, spd);
            dhb_pkg::OP_RAMP:
                if (!tick_en || len == 0)
                    drive_now(ch, d, spd);
                else
                begin
                    start_duty[ch] = duty[ch];
                    goal_duty[ch] = spd;
                    ms_done[ch] = '0;
                    ms_total[ch] = len;
                    ramping[ch] = 1'b1;
                    if (d != heading[ch])
                    begin
                        brake_beat(ch);
                        start_duty[ch] = 10'(SPEED_MAX);
                    end
                    heading[ch] = d;
                    pins[ch] = dhb_pkg::dir_pins(d);
                end
            dhb_pkg::OP_BRAKE:
            begin
                ramping[ch] = 1'b0;
                pins[ch] = dhb_pkg::PINS_BRAKE;
                duty[ch] = 10'(SPEED_MAX);
            end
            dhb_pkg::OP_COAST:
            begin
                ramping[ch] = 1'b0;
                pins[ch] = dhb_pkg::PINS_OFF;
                duty[ch] = 10'd0;
            end
            dhb_pkg::OP_STBY_ON:
            begin
                for (int c = 0; c < 2; c++)
                begin
                    pins[c] = dhb_pkg::PINS_OFF;
                    duty[c] = 10'd0;
                    ramping[c] = 1'b0;
                end
                stby_lvl = 1'b0;
            end
            dhb_pkg::OP_STBY_OFF:
                stby_lvl = 1'b1;
            dhb_pkg::OP_ESTOP:
                for (int c = 0; c < 2; c++)
                begin
                    ramping[c] = 1'b0;
                    pins[c] = dhb_pkg::PINS_BRAKE;
                    duty[c] = 10'(SPEED_MAX);
                end
            default:
                if (tick_en)
                begin
                    advance_ramp(0);
                    advance_ramp(1);
                end
        endcase
        push_snapshot(1'b1);
    endtask

    // Track config and command beats, and compare each result beat.
    always @(posedge clk or negedge rst_n)
    begin
        snap_t got;
        snap_t want;
        if (!rst_n)
        begin
            tick_en = 1'b1;
            stby_lvl = 1'b1;
            for (int c = 0; c < 2; c++)
            begin
                duty[c] = '0;
                heading[c] = 1'b0;
                pins[c] = dhb_pkg::PINS_OFF;
                ramping[c] = 1'b0;
                start_duty[c] = '0;
                goal_duty[c] = '0;
                ms_done[c] = '0;
                ms_total[c] = '0;
            end
            snap_q.delete();
            fail_count <= 0;
            pending <= 0;
            beats_seen <= 0;
            pulses_seen <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {pwm_a, pwm_b, in1_a, in2_a, in1_b, in2_b, standby_pin,
                       dir_a, dir_b, last};
                beats_seen <= beats_seen + 1;
                if (!last)
                    pulses_seen <= pulses_seen + 1;
                if (snap_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: unexpected result beat %p", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = snap_q.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < 10)
                            $display("ERROR: result mismatch expected %p actual %p",
                                     want, got);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                tick_en = cfg_data;
            if (in_valid && in_ready)
                predict_command(dhb_pkg::op_t'(op), int'(channel), direction, speed,
                                ramp_ms);
            pending <= snap_q.size();
        end
    end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Dual bridge controller testbench
// Directed commands over every opcode and field extreme, then random ramp
// sequences with ticks, under bursty command traffic and a stalling result
// side; the checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;

    localparam int SPEED_MAX = 1000;
    localparam int CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  op;
    logic        channel;
    logic        direction;
    logic [9:0]  speed;
    logic [31:0] ramp_ms;
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [9:0]  pwm_a;
    logic [9:0]  pwm_b;
    logic        in1_a;
    logic        in2_a;
    logic        in1_b;
    logic        in2_b;
    logic        standby_pin;
    logic        dir_a;
    logic        dir_b;
    logic        last;
    int          fail_count;
    int          pending;
    int          beats_seen;
    int          pulses_seen;
    int          cycle_count = 0;
    int          stall_mode = 0;
    int          cmds_sent;

    dual_hbridge_speed_ramp_controller #(.SPEED_MAX(SPEED_MAX)) DUT (.*);

    dhb_checker #(.SPEED_MAX(SPEED_MAX)) u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side stalls: modes of always ready, light and heavy backpressure.
    always @(posedge clk)
    begin
        if (($urandom % 300) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= ($urandom % 4) != 0;
            default: out_ready <= ($urandom % 4) == 0;
        endcase
    end

    // Send one command beat, holding it until accepted, then one time in eight a random gap.
    task automatic send_cmd(input dhb_pkg::op_t o, input logic ch, input logic d,
                            input logic [9:0] spd, input logic [31:0] len);
        op <= o;
        channel <= ch;
        direction <= d;
        speed <= spd;
        ramp_ms <= len;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        cmds_sent++;
        if (($urandom % 8) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    // Drain every expected beat, allow the tick latency, then write the register.
    task automatic set_ramp_enable(input logic v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [9:0] rand_speed();
        case ($urandom % 6)
            0: return 10'd0;
            1: return 10'd1023;
            2: return 10'(SPEED_MAX);
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic logic [31:0] rand_length();
        case ($urandom % 10)
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom;
            3: return 32'd1;
            default: return 32'($urandom_range(1, 12));
        endcase
    endfunction

    // A ramp with a run of ticks, mostly long enough to finish it.
    task automatic ramp_sequence();
        logic ch;
        logic [31:0] len;
        ch = 1'($urandom);
        len = rand_length();
        send_cmd(dhb_pkg::OP_RAMP, ch, 1'($urandom), rand_speed(), len);
        if (($urandom % 3) == 0)
            send_cmd(dhb_pkg::OP_RAMP, ~ch, 1'($urandom), rand_speed(), rand_length());
        repeat ((len < 14) ? len + $urandom_range(0, 2) : $urandom_range(1, 8))
            send_cmd(dhb_pkg::OP_TICK, 1'($urandom), 1'($urandom), 10'($urandom),
                     $urandom);
    endtask

    task automatic random_phase(input int n);
        int start;
        start = cmds_sent;
        while (cmds_sent - start < n)
        begin
            if (($urandom % 10) < 6)
                ramp_sequence();
            else
                send_cmd(dhb_pkg::op_t'($urandom_range(0, 7)), 1'($urandom),
                         1'($urandom), rand_speed(), rand_length());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        in_valid = 1'b0;
        op = dhb_pkg::OP_RUN;
        channel = 1'b0;
        direction = 1'b0;
        speed = '0;
        ramp_ms = '0;
        cmds_sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every opcode, field extremes, direction changes, ticks.
        send_cmd(dhb_pkg::OP_TICK, 1'b0, 1'b0, 10'd0, 32'd0);
        send_cmd(dhb_pkg::OP_RUN, 1'b0, 1'b0, 10'd1023, 32'hFFFF_FFFF);
        send_cmd(dhb_pkg::OP_RUN, 1'b0, 1'b1, 10'd500, 32'd0);
        send_cmd(dhb_pkg::OP_RUN, 1'b1, 1'b1, 10'd0, 32'd0);
        send_cmd(dhb_pkg::OP_RAMP, 1'b0, 1'b1, 10'd0, 32'd4);
        send_cmd(dhb_pkg::OP_RAMP, 1'b1, 1'b0, 10'd1000, 32'd3);
        repeat (5) send_cmd(dhb_pkg::OP_TICK, 1'b1, 1'b1, 10'd1023, 32'hFFFF_FFFF);
        send_cmd(dhb_pkg::OP_RAMP, 1'b0, 1'b1, 10'd999, 32'd0);
        send_cmd(dhb_pkg::OP_RAMP, 1'b1, 1'b0, 10'd7, 32'hFFFF_FFFF);
        send_cmd(dhb_pkg::OP_TICK, 1'b0, 1'b0, 10'd0, 32'd0);
        send_cmd(dhb_pkg::OP_STBY_ON, 1'b0, 1'b0, 10'd0, 32'd0);
        send_cmd(dhb_pkg::OP_RUN, 1'b1, 1'b1, 10'd300, 32'd0);
        send_cmd(dhb_pkg::OP_STBY_OFF, 1'b1, 1'b0, 10'd0, 32'd0);
        send_cmd(dhb_pkg::OP_RAMP, 1'b0, 1'b0, 10'd800, 32'd2);
        send_cmd(dhb_pkg::OP_BRAKE, 1'b0, 1'b0, 10'd0, 32'd0);
        send_cmd(dhb_pkg::OP_COAST, 1'b1, 1'b1, 10'd0, 32'd0);
        send_cmd(dhb_pkg::OP_ESTOP, 1'b0, 1'b0, 10'd0, 32'd0);
        send_cmd(dhb_pkg::OP_TICK, 1'b0, 1'b0, 10'd0, 32'd0);

        // Ramp enable off: ramps act as runs, ticks change nothing.
        set_ramp_enable(1'b0);
        send_cmd(dhb_pkg::OP_RAMP, 1'b0, 1'b0, 10'd250, 32'd5);
        send_cmd(dhb_pkg::OP_TICK, 1'b0, 1'b0, 10'd0, 32'd0);
        random_phase(300);
        set_ramp_enable(1'b1);
        random_phase(900);

        // Freeze ramps in progress, then resume them.
        send_cmd(dhb_pkg::OP_RAMP, 1'b0, 1'b1, 10'd600, 32'd6);
        set_ramp_enable(1'b0);
        random_phase(150);
        set_ramp_enable(1'b1);
        random_phase(550);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Covered %0d commands giving %0d result beats, %0d brake pulses.",
                 cmds_sent, beats_seen, pulses_seen);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
hdl/dhb_pkg.sv
hdl/dhb_divider.sv
hdl/dual_hbridge_speed_ramp_controller.sv
bench/dhb_checker.sv
bench/tb.sv
